/* src/csp_pkg.sv */
// Shared types, constants and rounding helpers for the cardinal spline point core.
// No dependencies; imported by cardinal_spline_point_evaluator_core.
`timescale 1ns / 1ps

package csp_pkg;

  localparam int U_FRAC_BITS   = 16;
  localparam int U_W           = 16;
  localparam int COUNT_W       = 7;
  localparam int COORD_WIDTH   = 20;
  localparam int W_W           = 20;
  localparam int TEN_W         = 15;
  localparam int TEN_Q         = 14;
  localparam int MAX_SWEEP_DEF = 64;

  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 60;
  localparam int IN_TDATA_W    = 24;
  localparam int OUT_TDATA_W   = 160;

  // Widths inside the weight and position datapath
  localparam int PROD_W = 36;
  localparam int RAW_W  = 40;
  localparam int PPOS_W = 2 * COORD_WIDTH;
  localparam int ACC_W  = PPOS_W + 2;

  localparam int W_SHIFT = U_FRAC_BITS + TEN_Q - 16;

  localparam logic [TEN_W-1:0] TENSION_RST = TEN_W'(8192);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TENSION = 3'd0,
    REG_CTRL_0  = 3'd1,
    REG_CTRL_1  = 3'd2,
    REG_CTRL_2  = 3'd3,
    REG_CTRL_3  = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_DIV,
    SEQ_SWEEP
  } seq_state_t;

  // Round to nearest (ties up) from Q(F+14) to Q16, clamp to the weight range
  function automatic logic signed [W_W-1:0] rnd_sat_weight(input logic signed [RAW_W-1:0] x);
    logic signed [RAW_W-1:0] y;
    logic signed [RAW_W-1:0] s;
    logic signed [RAW_W-1:0] hi;
    logic signed [RAW_W-1:0] lo;
    y  = x + (RAW_W'(1) <<< (W_SHIFT - 1));
    s  = y >>> W_SHIFT;
    hi = (RAW_W'(1) <<< (W_W - 1)) - RAW_W'(1);
    lo = -hi - RAW_W'(1);
    if (s > hi) begin
      return hi[W_W-1:0];
    end else if (s < lo) begin
      return lo[W_W-1:0];
    end
    return s[W_W-1:0];
  endfunction

  // Round the Q16 coordinate sum to integer, clamp to the coordinate range
  function automatic logic signed [COORD_WIDTH-1:0] rnd_sat_pos(input logic signed [ACC_W-1:0] x);
    logic signed [ACC_W-1:0] y;
    logic signed [ACC_W-1:0] s;
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    y  = x + (ACC_W'(1) <<< 15);
    s  = y >>> 16;
    hi = (ACC_W'(1) <<< (COORD_WIDTH - 1)) - ACC_W'(1);
    lo = -hi - ACC_W'(1);
    if (s > hi) begin
      return hi[COORD_WIDTH-1:0];
    end else if (s < lo) begin
      return lo[COORD_WIDTH-1:0];
    end
    return s[COORD_WIDTH-1:0];
  endfunction

endpackage

/* src/cardinal_spline_point_evaluator_core.sv */
// A single-point transaction passes through stage registers s1..s6 and the output register after acceptance.
// Throughput: single points 1 per cycle through a 7-register pipeline that stalls as one.
// A sweep of n points first runs the bit-serial step divider (2^17 / 2n), then issues
// one point per cycle while the output side takes them.
// Reset (rst_n low, synchronous): sequencer idle, pipeline empty, tension 0.5, points zero.
// Depends on csp_pkg.
`timescale 1ns / 1ps

module cardinal_spline_point_evaluator_core
  import csp_pkg::*;
#(
  parameter int MAX_SWEEP = MAX_SWEEP_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // configuration write channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // u_in[15:0], count[22:16], zero[23]
  input  logic                   in_tuser,   // kind
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // u_out, pos_x, pos_y, pos_z, weight_0..3, zero pad
  output logic                   out_tlast   // last
);

  localparam int CNT_W     = $clog2(MAX_SWEEP + 1);
  localparam int KCNT_W    = $clog2(MAX_SWEEP);
  localparam int STEP_W    = U_FRAC_BITS + 1;
  localparam int DIV_TOP   = U_FRAC_BITS + 1;
  localparam int DIV_CNT_W = $clog2(DIV_TOP + 1);

  // ---------------- configuration registers ----------------
  logic [TEN_W-1:0]      tension_r;
  logic [CFG_DATA_W-1:0] ctrl_r [4];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tension_r <= TENSION_RST;
      for (int j = 0; j < 4; j++) begin
        ctrl_r[j] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TENSION: tension_r <= cfg_data[TEN_W-1:0];
        REG_CTRL_0:  ctrl_r[0] <= cfg_data;
        REG_CTRL_1:  ctrl_r[1] <= cfg_data;
        REG_CTRL_2:  ctrl_r[2] <= cfg_data;
        REG_CTRL_3:  ctrl_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- input fields ----------------
  logic               in_kind;
  logic [U_W-1:0]     in_u;
  logic [COUNT_W-1:0] in_count;
  logic [CNT_W-1:0]   n_clamp;

  assign in_kind  = in_tuser;
  assign in_u     = in_tdata[U_W-1:0];
  assign in_count = in_tdata[U_W +: COUNT_W];

  always_comb begin
    if (in_count == '0) begin
      n_clamp = CNT_W'(1);
    end else if (in_count > COUNT_W'(MAX_SWEEP)) begin
      n_clamp = CNT_W'(MAX_SWEEP);
    end else begin
      n_clamp = CNT_W'(in_count);
    end
  end

  // ---------------- pipeline enable ----------------
  logic out_tvalid_r;
  logic pipe_en;

  assign pipe_en = !out_tvalid_r || out_tready;

  // ---------------- sweep sequencer ----------------
  seq_state_t           seq_state_r;
  seq_state_t           seq_state_nxt;
  logic [CNT_W-1:0]     n_r;
  logic [CNT_W:0]       two_n;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic [CNT_W:0]       div_rem_r;
  logic [STEP_W-1:0]    div_q_r;
  logic [CNT_W+1:0]     div_trial;
  logic                 div_ge;
  logic [CNT_W:0]       sw_rem_r;
  logic [STEP_W-1:0]    sw_u_r;
  logic [KCNT_W-1:0]    sw_k_r;
  logic [CNT_W+1:0]     sw_sum;
  logic                 sw_wrap;
  logic                 sw_last;
  logic                 in_acc;
  logic                 issue_valid;
  logic [U_W-1:0]       issue_u;
  logic                 issue_last;

  assign two_n     = {n_r, 1'b0};
  assign div_trial = {div_rem_r, (div_cnt_r == DIV_CNT_W'(DIV_TOP))};
  assign div_ge    = div_trial >= (CNT_W + 2)'(two_n);
  assign sw_sum    = (CNT_W + 2)'(sw_rem_r) + (CNT_W + 2)'(div_rem_r);
  assign sw_wrap   = sw_sum >= (CNT_W + 2)'(two_n);
  assign sw_last   = (CNT_W'(sw_k_r) == (n_r - CNT_W'(1)));
  assign in_acc    = in_tvalid && in_tready;

  // next state
  always_comb begin
    seq_state_nxt = seq_state_r;
    unique case (seq_state_r)
      SEQ_IDLE: begin
        if (in_acc && in_kind) begin
          seq_state_nxt = SEQ_DIV;
        end
      end
      SEQ_DIV: begin
        if (div_cnt_r == '0) begin
          seq_state_nxt = SEQ_SWEEP;
        end
      end
      SEQ_SWEEP: begin
        if (pipe_en && sw_last) begin
          seq_state_nxt = SEQ_IDLE;
        end
      end
      default: seq_state_nxt = SEQ_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_tready   = 1'b0;
    issue_valid = 1'b0;
    issue_u     = in_u;
    issue_last  = 1'b1;
    unique case (seq_state_r)
      SEQ_IDLE: begin
        in_tready   = pipe_en;
        issue_valid = in_tvalid && pipe_en && !in_kind;
      end
      SEQ_DIV: ;
      SEQ_SWEEP: begin
        issue_valid = pipe_en;
        issue_u     = sw_u_r[U_W-1:0];
        issue_last  = sw_last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_state_r <= SEQ_IDLE;
    end else begin
      seq_state_r <= seq_state_nxt;
    end
  end

  // divider and sweep stepping: u advances by 2^17/2n in quotient and remainder form
  always_ff @(posedge clk) begin
    unique case (seq_state_r)
      SEQ_IDLE: begin
        if (in_acc && in_kind) begin
          n_r       <= n_clamp;
          div_cnt_r <= DIV_CNT_W'(DIV_TOP);
          div_rem_r <= '0;
          div_q_r   <= '0;
        end
      end
      SEQ_DIV: begin
        div_rem_r <= div_ge ? (CNT_W + 1)'(div_trial - (CNT_W + 2)'(two_n))
                            : (CNT_W + 1)'(div_trial);
        div_q_r   <= {div_q_r[STEP_W-2:0], div_ge};
        div_cnt_r <= div_cnt_r - DIV_CNT_W'(1);
        if (div_cnt_r == '0) begin
          sw_rem_r <= (CNT_W + 1)'(n_r);
          sw_u_r   <= '0;
          sw_k_r   <= '0;
        end
      end
      SEQ_SWEEP: begin
        if (pipe_en) begin
          sw_rem_r <= sw_wrap ? (CNT_W + 1)'(sw_sum - (CNT_W + 2)'(two_n))
                              : (CNT_W + 1)'(sw_sum);
          sw_u_r   <= sw_u_r + div_q_r + STEP_W'(sw_wrap);
          sw_k_r   <= sw_k_r + KCNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  // ---------------- evaluation pipeline ----------------
  logic s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r, s5_valid_r, s6_valid_r;
  logic s1_last_r, s2_last_r, s3_last_r, s4_last_r, s5_last_r, s6_last_r;
  logic [U_W-1:0] s1_u_r, s2_u_r, s3_u_r, s4_u_r, s5_u_r, s6_u_r;
  logic [U_W-1:0] s2_u2_r, s3_u2_r;
  logic [U_W-1:0] s3_u3_r;

  logic [2*U_W:0] sq_nxt;
  logic [2*U_W:0] cube_nxt;

  assign sq_nxt   = (2 * U_W + 1)'(s1_u_r * s1_u_r) + (2 * U_W + 1)'(1 << (U_FRAC_BITS - 1));
  assign cube_nxt = (2 * U_W + 1)'(s2_u2_r * s2_u_r) + (2 * U_W + 1)'(1 << (U_FRAC_BITS - 1));

  // basis products (stage 4)
  logic signed [16:0] t_s;
  logic signed [16:0] k_a1, k_b1, k_c2, k_d2;
  logic signed [18:0] u1_s, u2_s, u3_s, d0_s, d3_s;
  logic signed [PROD_W-1:0] p0_nxt, a1_nxt, b1_nxt, a2_nxt, c2_nxt, d2_nxt, p3_nxt;
  logic signed [PROD_W-1:0] p0_r, a1_r, b1_r, a2_r, c2_r, d2_r, p3_r;

  always_comb begin
    t_s    = signed'({2'b00, tension_r});
    k_a1   = t_s - 17'sd49152;
    k_b1   = 17'sd32768 - t_s;
    k_c2   = 17'sd49152 - (t_s <<< 1);
    k_d2   = t_s - 17'sd32768;
    u1_s   = signed'({3'b000, s3_u_r});
    u2_s   = signed'({3'b000, s3_u2_r});
    u3_s   = signed'({3'b000, s3_u3_r});
    d0_s   = (u2_s <<< 1) - u1_s - u3_s;
    d3_s   = u3_s - u2_s;
    p0_nxt = t_s * d0_s;
    a1_nxt = k_a1 * u2_s;
    b1_nxt = k_b1 * u3_s;
    a2_nxt = t_s * u1_s;
    c2_nxt = k_c2 * u2_s;
    d2_nxt = k_d2 * u3_s;
    p3_nxt = t_s * d3_s;
  end

  // weights (stage 5)
  logic signed [RAW_W-1:0] raw_nxt [4];
  logic signed [W_W-1:0]   s5_w_r [4];
  logic signed [W_W-1:0]   s6_w_r [4];

  always_comb begin
    raw_nxt[0] = p0_r;
    raw_nxt[1] = (RAW_W'(1) <<< (U_FRAC_BITS + TEN_Q)) + a1_r + b1_r;
    raw_nxt[2] = a2_r + c2_r + d2_r;
    raw_nxt[3] = p3_r;
  end

  // position products (stage 6)
  logic signed [PPOS_W-1:0] pp_nxt [3][4];
  logic signed [PPOS_W-1:0] pp_r   [3][4];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      for (int j = 0; j < 4; j++) begin
        pp_nxt[c][j] = s5_w_r[j] * $signed(ctrl_r[j][c*COORD_WIDTH +: COORD_WIDTH]);
      end
    end
  end

  // coordinate sums (output register)
  logic signed [ACC_W-1:0]       acc_nxt [3];
  logic signed [COORD_WIDTH-1:0] pos_r   [3];
  logic signed [W_W-1:0]         out_w_r [4];
  logic [U_W-1:0]                out_u_r;
  logic                          out_last_r;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      acc_nxt[c] = ACC_W'(pp_r[c][0]) + ACC_W'(pp_r[c][1]) + ACC_W'(pp_r[c][2])
                 + ACC_W'(pp_r[c][3]);
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      s2_valid_r   <= 1'b0;
      s3_valid_r   <= 1'b0;
      s4_valid_r   <= 1'b0;
      s5_valid_r   <= 1'b0;
      s6_valid_r   <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else if (pipe_en) begin
      s1_valid_r   <= issue_valid;
      s2_valid_r   <= s1_valid_r;
      s3_valid_r   <= s2_valid_r;
      s4_valid_r   <= s3_valid_r;
      s5_valid_r   <= s4_valid_r;
      s6_valid_r   <= s5_valid_r;
      out_tvalid_r <= s6_valid_r;
    end
  end

  // payload, held whole while the output side stalls
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s1_u_r    <= issue_u;
      s1_last_r <= issue_last;

      s2_u_r    <= s1_u_r;
      s2_last_r <= s1_last_r;
      s2_u2_r   <= sq_nxt[U_FRAC_BITS +: U_W];

      s3_u_r    <= s2_u_r;
      s3_last_r <= s2_last_r;
      s3_u2_r   <= s2_u2_r;
      s3_u3_r   <= cube_nxt[U_FRAC_BITS +: U_W];

      s4_u_r    <= s3_u_r;
      s4_last_r <= s3_last_r;
      p0_r      <= p0_nxt;
      a1_r      <= a1_nxt;
      b1_r      <= b1_nxt;
      a2_r      <= a2_nxt;
      c2_r      <= c2_nxt;
      d2_r      <= d2_nxt;
      p3_r      <= p3_nxt;

      s5_u_r    <= s4_u_r;
      s5_last_r <= s4_last_r;
      for (int j = 0; j < 4; j++) begin
        s5_w_r[j] <= rnd_sat_weight(raw_nxt[j]);
      end

      s6_u_r    <= s5_u_r;
      s6_last_r <= s5_last_r;
      s6_w_r    <= s5_w_r;
      pp_r      <= pp_nxt;

      out_u_r    <= s6_u_r;
      out_last_r <= s6_last_r;
      out_w_r    <= s6_w_r;
      for (int c = 0; c < 3; c++) begin
        pos_r[c] <= rnd_sat_pos(acc_nxt[c]);
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {4'b0000, out_w_r[3], out_w_r[2], out_w_r[1], out_w_r[0],
                       pos_r[2], pos_r[1], pos_r[0], out_u_r};

`ifndef NO_ASSERTIONS
  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_state_r != SEQ_IDLE) |-> !in_tready)
    else $error("input taken while a sweep is in progress");

  a_sweep_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_state_r == SEQ_SWEEP) |-> (sw_rem_r < two_n) && (div_rem_r < two_n))
    else $error("sweep remainder out of range");

  a_sweep_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_state_r == SEQ_SWEEP && pipe_en && sw_last) |=> (seq_state_r == SEQ_IDLE))
    else $error("sweep did not end after its last point");

  a_stall_holds_stage: assert property (@(posedge clk) disable iff (!rst_n)
    (!pipe_en && s6_valid_r) |=> s6_valid_r && $stable(s6_u_r))
    else $error("pipeline stage moved during a stall");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_state_r == SEQ_IDLE && issue_valid) |-> issue_last)
    else $error("single point issued without last");
`endif

endmodule
